// ----- rtl/zsa_pkg.sv -----
`timescale 1ns / 1ps

package zsa_pkg;

  // Default sizing of the block.
  localparam int ZONE_DEPTH_DEF   = 256;
  localparam int COUNT_WIDTH_DEF  = 24;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Port field widths.
  localparam int ACTION_W   = 2;
  localparam int ZONE_ID_W  = 8;
  localparam int PIXEL_W    = 16;
  localparam int ZONES_W    = 9;
  localparam int CELL_CNT_W = 24;
  localparam int VSUM_W     = 40;
  localparam int SQSUM_W    = 54;
  localparam int MEAN_W     = 24;
  localparam int VAR_W      = 39;
  localparam int FRAC_BITS  = 8;

  localparam logic [ZONES_W-1:0] ZONES_RESET = 9'd256;

  localparam logic [ACTION_W-1:0] ACT_ACCUM  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [CELL_CNT_W-1:0]    cell_count;
    logic signed [VSUM_W-1:0] value_sum;
    logic [SQSUM_W-1:0]       square_sum;
    logic signed [MEAN_W-1:0] mean_fixed;
    logic [VAR_W-1:0]         variance_fixed;
    logic                     count_overflow;
  } zsa_result_t;

endpackage

// ----- rtl/zsa_if.sv -----
`timescale 1ns / 1ps

interface zsa_in_if import zsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [ZONE_ID_W-1:0]      zone_id;
  logic                      inside_zone;
  logic                      no_data;
  logic signed [PIXEL_W-1:0] pixel_value;

  modport source (output valid, action, zone_id, inside_zone, no_data, pixel_value,
                  input ready);
  modport sink (input valid, action, zone_id, inside_zone, no_data, pixel_value,
                output ready);
endinterface

interface zsa_out_if import zsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CELL_CNT_W-1:0]     cell_count;
  logic signed [VSUM_W-1:0]  value_sum;
  logic [SQSUM_W-1:0]        square_sum;
  logic signed [MEAN_W-1:0]  mean_fixed;
  logic [VAR_W-1:0]          variance_fixed;
  logic                      count_overflow;

  modport source (output valid, cell_count, value_sum, square_sum, mean_fixed,
                  variance_fixed, count_overflow, input ready);
  modport sink (input valid, cell_count, value_sum, square_sum, mean_fixed,
                variance_fixed, count_overflow, output ready);
endinterface

interface zsa_cfg_if import zsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ZONES_W-1:0] zones_in_use;

  modport source (output valid, zones_in_use, input ready);
  modport sink (input valid, zones_in_use, output ready);
endinterface

// ----- rtl/zsa_ram.sv -----
`timescale 1ns / 1ps

module zsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/zsa_stats.sv -----
`timescale 1ns / 1ps

module zsa_stats import zsa_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_W        = COUNT_WIDTH + SAMPLE_WIDTH,
  parameter int SQ_W         = COUNT_WIDTH + 2 * SAMPLE_WIDTH - 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] n_i,
  input  logic [SUM_W-1:0]       s_i,
  input  logic [SQ_W-1:0]        sq_i,
  input  logic                   ov_i,
  input  logic                   ack,
  output logic                   res_valid,
  output zsa_result_t            res
);

  localparam int PW  = 2 * SUM_W;
  localparam int DW  = PW + FRAC_BITS;
  localparam int DVW = 2 * COUNT_WIDTH;
  localparam int CTW = $clog2(DW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DIVM = 3'd4;
  localparam logic [2:0] S_DIVV = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [CTW-1:0]         cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] n_r, n_nxt;
  logic [SUM_W-1:0]       s_r, s_nxt;
  logic [SUM_W-1:0]       a_r, a_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic                   ov_r, ov_nxt;
  logic [PW-1:0]          mcand_r, mcand_nxt;
  logic [SUM_W-1:0]       mplier_r, mplier_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [PW-1:0]          p1_r, p1_nxt;
  logic [DVW-1:0]         rem_r, rem_nxt;
  logic [DW-1:0]          quo_r, quo_nxt;
  logic [DVW-1:0]         dvs_r, dvs_nxt;
  logic [MEAN_W-1:0]      mean_r, mean_nxt;
  logic [VAR_W-1:0]       var_r, var_nxt;

  logic [DVW:0]           trial;
  logic                   ge;
  logic [DVW-1:0]         nsq;
  logic [MEAN_W-1:0]      q24;

  assign nsq = DVW'(n_r) * DVW'(n_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    s_nxt      = s_r;
    a_nxt      = a_r;
    sq_nxt     = sq_r;
    ov_nxt     = ov_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    p1_nxt     = p1_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    mean_nxt   = mean_r;
    var_nxt    = var_r;

    // One shift-add multiply step and one restoring divide step.
    if (mplier_r[0]) begin
      prod_nxt = prod_r + mcand_r;
    end
    trial = {rem_r, quo_r[DW-1]};
    ge    = (trial >= {1'b0, dvs_r});
    q24   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt  = n_i;
          s_nxt  = s_i;
          a_nxt  = s_i[SUM_W-1] ? (~s_i + SUM_W'(1)) : s_i;
          sq_nxt = sq_i;
          ov_nxt = ov_i;
          if (n_i == '0) begin
            mean_nxt  = '0;
            var_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            mcand_nxt  = PW'(sq_i);
            mplier_nxt = SUM_W'(n_i);
            prod_nxt   = '0;
            cnt_nxt    = '0;
            state_nxt  = S_MUL1;
          end
        end else begin
          prod_nxt = prod_r;
        end
      end
      S_MUL1: begin
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CTW'(1);
        if (cnt_r == CTW'(SUM_W - 1)) begin
          p1_nxt     = prod_nxt;
          mcand_nxt  = PW'(a_r);
          mplier_nxt = a_r;
          prod_nxt   = '0;
          cnt_nxt    = '0;
          state_nxt  = S_MUL2;
        end
      end
      S_MUL2: begin
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CTW'(1);
        if (cnt_r == CTW'(SUM_W - 1)) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        prod_nxt  = prod_r;
        // Rounding can never make n*sumsq fall below sum^2, but guard anyway.
        p1_nxt    = (p1_r >= prod_r) ? (p1_r - prod_r) : '0;
        quo_nxt   = DW'({a_r, {FRAC_BITS{1'b0}}});
        rem_nxt   = '0;
        dvs_nxt   = DVW'(n_r);
        cnt_nxt   = '0;
        state_nxt = S_DIVM;
      end
      S_DIVM: begin
        prod_nxt = prod_r;
        rem_nxt  = ge ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
        quo_nxt  = {quo_r[DW-2:0], ge};
        cnt_nxt  = cnt_r + CTW'(1);
        if (cnt_r == CTW'(DW - 1)) begin
          q24 = quo_nxt[MEAN_W-1:0];
          // Floor of a negative quotient rounds the magnitude up.
          if (s_r[SUM_W-1]) begin
            mean_nxt = ~(q24 + MEAN_W'(rem_nxt != '0)) + MEAN_W'(1);
          end else begin
            mean_nxt = q24;
          end
          quo_nxt   = {p1_r, {FRAC_BITS{1'b0}}};
          rem_nxt   = '0;
          dvs_nxt   = nsq;
          cnt_nxt   = '0;
          state_nxt = S_DIVV;
        end
      end
      S_DIVV: begin
        prod_nxt = prod_r;
        rem_nxt  = ge ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
        quo_nxt  = {quo_r[DW-2:0], ge};
        cnt_nxt  = cnt_r + CTW'(1);
        if (cnt_r == CTW'(DW - 1)) begin
          var_nxt   = quo_nxt[VAR_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        prod_nxt = prod_r;
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        prod_nxt  = prod_r;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    a_r      <= a_nxt;
    sq_r     <= sq_nxt;
    ov_r     <= ov_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
    p1_r     <= p1_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    mean_r   <= mean_nxt;
    var_r    <= var_nxt;
  end

  assign res_valid          = (state_r == S_DONE);
  assign res.cell_count     = CELL_CNT_W'(n_r);
  assign res.value_sum      = VSUM_W'($signed(s_r));
  assign res.square_sum     = SQSUM_W'(sq_r);
  assign res.mean_fixed     = mean_r;
  assign res.variance_fixed = var_r;
  assign res.count_overflow = ov_r;

endmodule

// ----- rtl/zonal_statistics_accumulator.sv -----
`timescale 1ns / 1ps

// Per-zone statistics over a pixel stream. Each zone keeps a count, a sum,
// a sum of squares and an overflow flag in one on-chip RAM entry. After reset
// the block sweeps the RAM to zero, one entry a cycle, and holds in_ch.ready
// low meanwhile; configuration writes are taken at any time. An accumulate
// beat reads the RAM, then modifies and writes the entry back; a clear or an
// ignored beat completes without leaving ST_IDLE. A report runs the bit-serial
// multiplier and the restoring divider that produce the mean and the variance;
// a report on an empty zone skips the arithmetic. A finished report waits in
// the output register while new beats are accepted.
module zonal_statistics_accumulator import zsa_pkg::*; #(
  parameter int ZONE_DEPTH   = ZONE_DEPTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  zsa_in_if.sink   in_ch,
  zsa_out_if.source out_ch,
  zsa_cfg_if.sink  cfg_ch
);

  localparam int AW    = $clog2(ZONE_DEPTH);
  localparam int SUM_W = COUNT_WIDTH + SAMPLE_WIDTH;
  localparam int SQ_W  = COUNT_WIDTH + 2 * SAMPLE_WIDTH - 1;
  localparam int EW    = 1 + COUNT_WIDTH + SUM_W + SQ_W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_RPT  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [AW-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic [ZONES_W-1:0]            zones_r;
  logic [AW-1:0]                 addr_r, addr_nxt;
  logic                          in_store_r, in_store_nxt;
  logic signed [SAMPLE_WIDTH-1:0] pix_r, pix_nxt;
  logic [2*SAMPLE_WIDTH-2:0]     sqr_r, sqr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  zsa_result_t                   out_res_r, out_res_nxt;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [EW-1:0]                 wdata;
  logic [EW-1:0]                 rdata;

  logic signed [SAMPLE_WIDTH-1:0]   pix_in;
  logic signed [2*SAMPLE_WIDTH-1:0] sqr_full;
  logic                          in_store_in;
  logic                          pix_ok;

  logic [SQ_W-1:0]               rd_sq;
  logic [SUM_W-1:0]              rd_sum;
  logic [COUNT_WIDTH-1:0]        rd_cnt;
  logic                          rd_ov;

  logic                          st_start;
  logic                          st_ack;
  logic                          st_valid;
  zsa_result_t                   st_res;

  assign pix_in      = in_ch.pixel_value[SAMPLE_WIDTH-1:0];
  assign sqr_full    = pix_in * pix_in;
  assign in_store_in = (32'(in_ch.zone_id) < ZONE_DEPTH);
  assign pix_ok      = !in_ch.no_data && in_ch.inside_zone && in_store_in &&
                       ({1'b0, in_ch.zone_id} < zones_r);

  assign rd_sq  = rdata[SQ_W-1:0];
  assign rd_sum = rdata[SQ_W +: SUM_W];
  assign rd_cnt = rdata[SQ_W+SUM_W +: COUNT_WIDTH];
  assign rd_ov  = rdata[EW-1];

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    in_store_nxt  = in_store_r;
    pix_nxt       = pix_r;
    sqr_nxt       = sqr_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    we            = 1'b0;
    waddr         = addr_r;
    wdata         = '0;
    st_start      = 1'b0;
    st_ack        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(ZONE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          addr_nxt     = AW'(in_ch.zone_id);
          in_store_nxt = in_store_in;
          pix_nxt      = pix_in;
          sqr_nxt      = sqr_full[2*SAMPLE_WIDTH-2:0];
          case (in_ch.action)
            ACT_ACCUM: begin
              if (pix_ok) begin
                state_nxt = ST_ACC;
              end
            end
            ACT_REPORT: begin
              state_nxt = ST_RPT;
            end
            ACT_CLEAR: begin
              if (in_store_in) begin
                we    = 1'b1;
                waddr = AW'(in_ch.zone_id);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ACC: begin
        we = 1'b1;
        if (rd_cnt == '1) begin
          wdata = {1'b1, rd_cnt, rd_sum, rd_sq};
        end else begin
          wdata = {rd_ov, rd_cnt + COUNT_WIDTH'(1), rd_sum + SUM_W'(pix_r),
                   rd_sq + SQ_W'(sqr_r)};
        end
        state_nxt = ST_IDLE;
      end
      ST_RPT: begin
        st_start  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (st_valid && (!out_valid_r || out_ch.ready)) begin
          st_ack        = 1'b1;
          out_res_nxt   = st_res;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      zones_r     <= ZONES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        zones_r <= cfg_ch.zones_in_use;
      end
    end
    addr_r     <= addr_nxt;
    in_store_r <= in_store_nxt;
    pix_r      <= pix_nxt;
    sqr_r      <= sqr_nxt;
    out_res_r  <= out_res_nxt;
  end

  zsa_ram #(
    .WIDTH (EW),
    .DEPTH (ZONE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_nxt),
    .rdata (rdata)
  );

  // A zone outside the store reports as an empty zone.
  zsa_stats #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_W        (SUM_W),
    .SQ_W         (SQ_W)
  ) u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (st_start),
    .n_i       (in_store_r ? rd_cnt : '0),
    .s_i       (in_store_r ? rd_sum : '0),
    .sq_i      (in_store_r ? rd_sq : '0),
    .ov_i      (in_store_r && rd_ov),
    .ack       (st_ack),
    .res_valid (st_valid),
    .res       (st_res)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_count     = out_res_r.cell_count;
  assign out_ch.value_sum      = out_res_r.value_sum;
  assign out_ch.square_sum     = out_res_r.square_sum;
  assign out_ch.mean_fixed     = out_res_r.mean_fixed;
  assign out_ch.variance_fixed = out_res_r.variance_fixed;
  assign out_ch.count_overflow = out_res_r.count_overflow;

endmodule

// ----- sim/zsa_checker.sv -----
`timescale 1ns / 1ps

module zsa_checker import zsa_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  zsa_in_if    in_ch,
  zsa_out_if   out_ch,
  zsa_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending_reports
);

  localparam int ZONES = ZONE_DEPTH_DEF;
  localparam logic [CELL_CNT_W-1:0] COUNT_FULL = {CELL_CNT_W{1'b1}};

  logic [CELL_CNT_W-1:0]    zone_cnt [ZONES];
  logic signed [VSUM_W-1:0] zone_sum [ZONES];
  logic [SQSUM_W:0]         zone_sq  [ZONES];
  logic                     zone_ovf [ZONES];
  logic [ZONES_W-1:0]       zones_active;
  zsa_result_t              expected_reports[$];

  assign pending_reports = expected_reports.size();

  function automatic zsa_result_t zone_report(input int z);
    zsa_result_t r;
    logic signed [127:0] n, s, sq, mean_val, var_num, var_val;
    n  = zone_cnt[z];
    s  = zone_sum[z];
    sq = zone_sq[z];
    r.cell_count     = zone_cnt[z];
    r.value_sum      = zone_sum[z];
    r.square_sum     = sq[SQSUM_W-1:0];
    r.count_overflow = zone_ovf[z];
    mean_val = 0;
    var_val  = 0;
    if (n != 0) begin
      // Floor division of a possibly negative numerator.
      mean_val = (s * 256) / n;
      if ((s < 0) && (mean_val * n != s * 256)) mean_val = mean_val - 1;
      var_num = n * sq - s * s;
      if (var_num > 0) var_val = (var_num * 256) / (n * n);
    end
    r.mean_fixed     = mean_val[MEAN_W-1:0];
    r.variance_fixed = var_val[VAR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ZONES; i++) begin
        zone_cnt[i] <= '0;
        zone_sum[i] <= '0;
        zone_sq[i]  <= '0;
        zone_ovf[i] <= 1'b0;
      end
      zones_active <= ZONES_RESET;
      expected_reports.delete();
      fail_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) zones_active <= cfg_ch.zones_in_use;
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.action)
          ACT_ACCUM: begin
            if (!in_ch.no_data && in_ch.inside_zone && (in_ch.zone_id < zones_active)) begin
              if (zone_cnt[in_ch.zone_id] == COUNT_FULL) begin
                zone_ovf[in_ch.zone_id] <= 1'b1;
              end else begin
                zone_cnt[in_ch.zone_id] <= zone_cnt[in_ch.zone_id] + 1'b1;
                zone_sum[in_ch.zone_id] <= zone_sum[in_ch.zone_id] + in_ch.pixel_value;
                zone_sq[in_ch.zone_id]  <= zone_sq[in_ch.zone_id]
                    + 55'(in_ch.pixel_value * in_ch.pixel_value);
              end
            end
          end
          ACT_REPORT: expected_reports = {expected_reports, zone_report(in_ch.zone_id)};
          ACT_CLEAR: begin
            zone_cnt[in_ch.zone_id] <= '0;
            zone_sum[in_ch.zone_id] <= '0;
            zone_sq[in_ch.zone_id]  <= '0;
            zone_ovf[in_ch.zone_id] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected report beat at %0t", $realtime);
        end else begin
          zsa_result_t e;
          zsa_result_t a;
          e = expected_reports.pop_front();
          a.cell_count     = out_ch.cell_count;
          a.value_sum      = out_ch.value_sum;
          a.square_sum     = out_ch.square_sum;
          a.mean_fixed     = out_ch.mean_fixed;
          a.variance_fixed = out_ch.variance_fixed;
          a.count_overflow = out_ch.count_overflow;
          if (a !== e) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("Report mismatch at %0t", $realtime);
              $display("  count exp %0d got %0d, sum exp %0d got %0d", e.cell_count,
                       a.cell_count, e.value_sum, a.value_sum);
              $display("  sq exp %0d got %0d, mean exp %0d got %0d", e.square_sum,
                       a.square_sum, e.mean_fixed, a.mean_fixed);
              $display("  var exp %0d got %0d, ovf exp %0b got %0b", e.variance_fixed,
                       a.variance_fixed, e.count_overflow, a.count_overflow);
            end
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import zsa_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_RSVD = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_reports;
  int   send_idle_pct = 37;
  int   recv_idle_pct = 58;
  bit   recv_hold = 1'b0;
  longint cycle_count = 0;

  zsa_in_if  in_ch();
  zsa_out_if out_ch();
  zsa_cfg_if cfg_ch();

  zonal_statistics_accumulator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  zsa_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_reports(pending_reports)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [ZONE_ID_W-1:0] zone,
                           input logic in_zone, input logic nd, input logic [PIXEL_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.zone_id     <= zone;
    in_ch.inside_zone <= in_zone;
    in_ch.no_data     <= nd;
    in_ch.pixel_value <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_reports != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_zones(input logic [ZONES_W-1:0] zones);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.zones_in_use <= zones;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_beats(input int count, input int zmax);
    logic [ACTION_W-1:0] act;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      act = (r < 80) ? ACT_ACCUM : (r < 92) ? ACT_REPORT : (r < 97) ? ACT_CLEAR : ACT_RSVD;
      send_beat(act, ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(zmax)),
                $urandom_range(15) != 0, $urandom_range(15) == 0, 16'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ACCUM;
    in_ch.zone_id = '0;
    in_ch.inside_zone = 1'b0;
    in_ch.no_data = 1'b0;
    in_ch.pixel_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.zones_in_use = ZONES_RESET;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty zone, extremes, invalid pixels, high zone, unused action.
    send_beat(ACT_REPORT, 8'd5, 1'b1, 1'b0, '0);
    send_beat(ACT_ACCUM, 8'd0, 1'b1, 1'b0, 16'h8000);
    send_beat(ACT_ACCUM, 8'd0, 1'b1, 1'b0, 16'h7fff);
    send_beat(ACT_ACCUM, 8'd0, 1'b1, 1'b0, 16'h8000);
    send_beat(ACT_ACCUM, 8'd0, 1'b1, 1'b1, 16'h1234);
    send_beat(ACT_ACCUM, 8'd0, 1'b0, 1'b0, 16'h1234);
    send_beat(ACT_REPORT, 8'd0, 1'b0, 1'b0, '0);
    send_beat(ACT_ACCUM, 8'd255, 1'b1, 1'b0, 16'hffff);
    send_beat(ACT_ACCUM, 8'd255, 1'b1, 1'b0, 16'hfffe);
    send_beat(ACT_REPORT, 8'd255, 1'b1, 1'b0, '0);
    send_beat(ACT_RSVD, 8'd255, 1'b1, 1'b0, 16'h5555);
    send_beat(ACT_CLEAR, 8'd255, 1'b1, 1'b0, '0);
    send_beat(ACT_REPORT, 8'd255, 1'b1, 1'b0, '0);
    go_idle();
    write_zones(9'd1);
    send_beat(ACT_ACCUM, 8'd1, 1'b1, 1'b0, 16'h0100);
    send_beat(ACT_REPORT, 8'd1, 1'b1, 1'b0, '0);
    send_beat(ACT_REPORT, 8'd0, 1'b1, 1'b0, '0);
    go_idle();
    write_zones(9'd0);
    send_beat(ACT_ACCUM, 8'd0, 1'b1, 1'b0, 16'h0001);
    send_beat(ACT_REPORT, 8'd0, 1'b1, 1'b0, '0);
    go_idle();
    write_zones(9'h1ff);

    random_beats(300, 7);
    // Long receiver hold-off while the sender keeps offering beats.
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        random_beats(100, 3);
        // The last beat must not be offered again while the hold-off runs.
        in_ch.valid <= 1'b0;
      end
    join
    go_idle();
    write_zones(9'd5);
    send_idle_pct = 58;
    recv_idle_pct = 37;
    random_beats(300, 15);
    go_idle();
    write_zones(9'd256);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_beats(300, 255);
    go_idle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
